[design/pcm_pkg.sv]
// Shared types, constants and channel arithmetic for the pixel color math compositor.
`default_nettype none
package pcm_pkg;

    localparam int COLOR_W = 15;
    localparam int CHAN_W  = 5;
    localparam int SRC_W   = 3;
    localparam int BRIGHT_W = 4;
    localparam int MASK_W  = 7;

    localparam logic [SRC_W-1:0] NO_MATH_SOURCE  = 3'd5;
    localparam logic [SRC_W-1:0] BACKDROP_SOURCE = 3'd6;
    localparam logic [SRC_W-1:0] UNUSED_SOURCE   = 3'd7;

    localparam logic [2:0] REG_SUBTRACT_MODE = 3'd0;
    localparam logic [2:0] REG_USE_SUBSCREEN = 3'd1;
    localparam logic [2:0] REG_HALVE_ENABLE  = 3'd2;
    localparam logic [2:0] REG_MATH_MASK     = 3'd3;
    localparam logic [2:0] REG_FIXED_COLOR   = 3'd4;
    localparam logic [2:0] REG_BRIGHTNESS    = 3'd5;
    localparam logic [2:0] REG_HIRES_ENABLE  = 3'd6;

    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [SRC_W-1:0]   source_t;

    typedef struct packed {
        logic                subtract_mode;
        logic                use_subscreen;
        logic                halve_enable;
        logic [MASK_W-1:0]   math_enable_mask;
        color_t              fixed_color;
        logic [BRIGHT_W-1:0] brightness;
        logic                hires_enable;
    } cfg_t;

    // 5-bit channel: halved or saturating add; clamped subtract, optionally halved.
    function automatic logic [CHAN_W-1:0] blend_channel(
        input logic [CHAN_W-1:0] x,
        input logic [CHAN_W-1:0] y,
        input logic              sub,
        input logic              halve
    );
        logic [CHAN_W:0]   wide;
        logic [CHAN_W-1:0] res;
        if (!sub) begin
            wide = {1'b0, x} + {1'b0, y};
            if (halve) begin
                res = wide[CHAN_W:1];
            end else begin
                res = wide[CHAN_W] ? {CHAN_W{1'b1}} : wide[CHAN_W-1:0];
            end
        end else begin
            wide = {1'b0, x} - {1'b0, y};
            res = wide[CHAN_W] ? {CHAN_W{1'b0}} : wide[CHAN_W-1:0];
            if (halve) begin
                res = {1'b0, res[CHAN_W-1:1]};
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[design/pixel_color_math_compositor.sv]
// Pixel color math compositor: input stage, two compose halves, result register, APB registers.
//
// Input beats arrive on the s_ stream: main and sub colors, their source layers and the
// two window bits. Each beat is captured in an input register; the color math runs in
// one combinational pass from there into the result register on the m_ stream.
// A result carries the RGB555 color and the current brightness; m_tlast marks the
// final result of an input pixel.
// An accepted input beat passes through the input register, then the result register.
// While the receiver keeps up, one input beat is taken every cycle. With hires enabled
// each input gives two result beats (sub half first, then main half), and the next
// input is taken only with the main half, as there is a single result register.
// When the receiver stalls, the result register holds its beat, the input register
// keeps one more pixel, and s_tready drops until the result register frees up.
// Registers sit on an APB port at byte address 4*index and must be written only while
// the block is idle; the block does not enforce this. Reset (aresetn low, synchronous)
// clears all registers to zero and empties both the input and result stages.
`default_nettype none
module pixel_color_math_compositor
    import pcm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // main_rgb[14:0], main_source[17:15], sub_rgb[32:18], sub_source[35:33],
    // window_main[36], window_sub[37], zero fill[39:38]
    input  wire logic [39:0] s_tdata,
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pixel_color[14:0], pixel_brightness[18:15], zero fill[23:19]
    output logic      [23:0] m_tdata,
    output logic             m_tlast
);

    cfg_t    cfg_reg;
    logic    wr_en;
    logic [2:0] reg_idx;

    logic    in_valid_reg;
    color_t  in_main_rgb_reg;
    source_t in_main_src_reg;
    color_t  in_sub_rgb_reg;
    source_t in_sub_src_reg;
    logic    in_win_main_reg;
    logic    in_win_sub_reg;
    logic    phase_reg;

    logic    out_valid_reg;
    color_t  out_color_reg;
    logic [BRIGHT_W-1:0] out_bright_reg;
    logic    out_last_reg;

    color_t  sub_half;
    color_t  main_half;
    logic    out_free;
    logic    advance;
    logic    send_sub;
    logic    item_done;
    logic    s_take;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SUBTRACT_MODE: cfg_reg.subtract_mode    <= pwdata[0];
                REG_USE_SUBSCREEN: cfg_reg.use_subscreen    <= pwdata[0];
                REG_HALVE_ENABLE:  cfg_reg.halve_enable     <= pwdata[0];
                REG_MATH_MASK:     cfg_reg.math_enable_mask <= pwdata[MASK_W-1:0];
                REG_FIXED_COLOR:   cfg_reg.fixed_color      <= pwdata[COLOR_W-1:0];
                REG_BRIGHTNESS:    cfg_reg.brightness       <= pwdata[BRIGHT_W-1:0];
                REG_HIRES_ENABLE:  cfg_reg.hires_enable     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SUBTRACT_MODE: prdata = {31'd0, cfg_reg.subtract_mode};
            REG_USE_SUBSCREEN: prdata = {31'd0, cfg_reg.use_subscreen};
            REG_HALVE_ENABLE:  prdata = {31'd0, cfg_reg.halve_enable};
            REG_MATH_MASK:     prdata = {25'd0, cfg_reg.math_enable_mask};
            REG_FIXED_COLOR:   prdata = {17'd0, cfg_reg.fixed_color};
            REG_BRIGHTNESS:    prdata = {28'd0, cfg_reg.brightness};
            REG_HIRES_ENABLE:  prdata = {31'd0, cfg_reg.hires_enable};
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------- datapath ----------------
    pcm_compose u_sub_half (
        .cfg          (cfg_reg),
        .first_color  (in_sub_rgb_reg),
        .first_src    (in_sub_src_reg),
        .second_color (in_main_rgb_reg),
        .second_src   (in_main_src_reg),
        .win_main     (in_win_main_reg),
        .win_sub      (in_win_sub_reg),
        .result       (sub_half)
    );

    pcm_compose u_main_half (
        .cfg          (cfg_reg),
        .first_color  (in_main_rgb_reg),
        .first_src    (in_main_src_reg),
        .second_color (in_sub_rgb_reg),
        .second_src   (in_sub_src_reg),
        .win_main     (in_win_main_reg),
        .win_sub      (in_win_sub_reg),
        .result       (main_half)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    // In hires mode the first beat of a pixel is the sub half.
    assign send_sub  = cfg_reg.hires_enable && !phase_reg;
    assign item_done = advance && !send_sub;
    assign s_tready  = !in_valid_reg || item_done;
    assign s_take    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (item_done) begin
                in_valid_reg <= 1'b0;
            end
            if (item_done) begin
                phase_reg <= 1'b0;
            end else if (advance) begin
                phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_main_rgb_reg <= s_tdata[14:0];
            in_main_src_reg <= s_tdata[17:15];
            in_sub_rgb_reg  <= s_tdata[32:18];
            in_sub_src_reg  <= s_tdata[35:33];
            in_win_main_reg <= s_tdata[36];
            in_win_sub_reg  <= s_tdata[37];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_color_reg  <= send_sub ? sub_half : main_half;
            out_bright_reg <= cfg_reg.brightness;
            out_last_reg   <= !send_sub;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_bright_reg, out_color_reg};
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

[design/pcm_compose.sv]
// Color math for one output half: window gating, math enable, halving and blend.
`default_nettype none
module pcm_compose
    import pcm_pkg::*;
(
    input  wire cfg_t    cfg,
    input  wire color_t  first_color,
    input  wire source_t first_src,
    input  wire color_t  second_color,
    input  wire source_t second_src,
    input  wire logic    win_main,
    input  wire logic    win_sub,
    output color_t       result
);

    color_t          first_eff;
    color_t          operand;
    logic [SRC_W:0]  unused_guard;
    logic [7:0]      mask_ext;
    logic            math_on;
    logic            halve;
    color_t          blended;

    assign mask_ext     = {1'b0, cfg.math_enable_mask};
    assign unused_guard = {1'b0, first_src};
    assign first_eff    = win_main ? first_color : '0;
    assign operand      = cfg.use_subscreen ? second_color : cfg.fixed_color;

    assign math_on = (first_src != NO_MATH_SOURCE) && (first_src != UNUSED_SOURCE)
                     && mask_ext[first_src] && win_sub && !unused_guard[SRC_W];

    // With the fixed color as operand halving is allowed; a subscreen backdrop operand blocks it.
    assign halve = cfg.halve_enable && win_main
                   && (!cfg.use_subscreen || (second_src != BACKDROP_SOURCE));

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            blended[c*CHAN_W +: CHAN_W] = blend_channel(first_eff[c*CHAN_W +: CHAN_W],
                                                        operand[c*CHAN_W +: CHAN_W],
                                                        cfg.subtract_mode, halve);
        end
    end

    always_comb begin
        if (!win_main && !win_sub) begin
            result = '0;
        end else if (!math_on) begin
            result = first_eff;
        end else begin
            result = blended;
        end
    end

endmodule
`default_nettype wire
